>>> src/serial_port_bit_engine_defines.svh
// Assertion macros shared by the serial port bit engine modules.
`ifndef SERIAL_PORT_BIT_ENGINE_DEFINES_SVH
`define SERIAL_PORT_BIT_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spe_pkg.sv
// Types, constants and pin helpers for the serial port bit engine.
package spe_pkg;

    typedef enum logic [1:0] {
        FUNC_TX_BIT    = 2'd0,
        FUNC_RX_TICK   = 2'd1,
        FUNC_PUSH      = 2'd2,
        FUNC_PIN_WRITE = 2'd3
    } t_func;

    localparam logic [25:0] PIN_TXD = 26'(1) << 2;
    localparam logic [25:0] PIN_RXD = 26'(1) << 3;
    localparam logic [25:0] PIN_RTS = 26'(1) << 4;
    localparam logic [25:0] PIN_CTS = 26'(1) << 5;
    localparam logic [25:0] PIN_DSR = 26'(1) << 6;
    localparam logic [25:0] PIN_CD  = 26'(1) << 8;
    localparam logic [25:0] PIN_DTR = 26'(1) << 20;
    localparam logic [25:0] PIN_RI  = 26'(1) << 22;

    localparam logic [25:0] GRP_TX_RX  = PIN_TXD | PIN_RXD;
    localparam logic [25:0] GRP_RTS    = PIN_RTS | PIN_CTS | PIN_DSR;
    localparam logic [25:0] GRP_CD     = PIN_CD | PIN_DTR | PIN_RI;

    localparam logic [4:0] PIN_FIRST = 5'd1;
    localparam logic [4:0] PIN_LAST  = 5'd25;

    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    localparam logic [3:0] FRAME_STOP = 4'd9;

    typedef struct packed {
        logic [1:0] func;
        logic       bit_value;
        logic [7:0] char_in;
        logic [4:0] pin_number;
    } t_item;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        in_valid;
        logic [7:0]  in_byte;
        logic        flag_edge;
        logic [25:0] port_pins;
        logic        queue_overflow;
        logic        queue_empty;
    } t_result;

    typedef struct packed {
        logic rd_issue;
        logic push;
        logic push_nl;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic room_one;
        logic room_two;
        logic empty_next;
    } t_q_stat;

    function automatic logic [25:0] drive_pins(logic [25:0] pins, logic [25:0] mask,
                                               logic level, logic loop);
        logic [25:0] m;
        m = mask;
        if (loop) begin
            if (|(mask & GRP_TX_RX)) m = m | GRP_TX_RX;
            if (|(mask & GRP_RTS)) m = m | GRP_RTS;
            if (|(mask & GRP_CD)) m = m | GRP_CD;
        end
        return level ? (pins | m) : (pins & ~m);
    endfunction

endpackage

>>> src/spe_ifs.sv
// Request channel interfaces of the serial port bit engine.
interface spe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       bit_value;
    logic [7:0] char_in;
    logic [4:0] pin_number;

    modport source(output valid, func, bit_value, char_in, pin_number, input ready);
    modport sink(input valid, func, bit_value, char_in, pin_number, output ready);
endinterface

interface spe_out_if;
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        flag_edge;
    logic [25:0] port_pins;
    logic        queue_overflow;
    logic        queue_empty;

    modport source(output valid, out_valid, out_byte, in_valid, in_byte, flag_edge,
                   port_pins, queue_overflow, queue_empty, input ready);
    modport sink(input valid, out_valid, out_byte, in_valid, in_byte, flag_edge,
                 port_pins, queue_overflow, queue_empty, output ready);
endinterface

interface spe_cfg_if;
    logic valid;
    logic ready;
    logic loopback_enable;

    modport source(output valid, loopback_enable, input ready);
    modport sink(input valid, loopback_enable, output ready);
endinterface

>>> src/serial_port_bit_engine.sv
// Serial port bit engine top level: deframer, RXD framer, pins and queue control.
// Results: an accepted request is held in r_s1, then registered in r_out when it fires.
// Throughput: one request per cycle unless the output stalls; a newline push holds off
// input, leaving a gap in which the carriage return takes the queue RAM's single write port.
// Reset (synchronous, active low) clears pins, framer, deframer, queue pointers
// and the loopback register; queue RAM contents stay undefined.
`include "serial_port_bit_engine_defines.svh"
module serial_port_bit_engine #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spe_in_if.sink      i_in,
    spe_out_if.source   o_out,
    spe_cfg_if.sink     i_cfg
);
    logic               r_loop;
    logic               r_s1_valid;
    spe_pkg::t_item     r_s1;
    logic               r_out_valid;
    spe_pkg::t_result   r_out;

    logic [25:0]        r_pins, n_pins;
    logic [3:0]         r_deframe_count, n_deframe_count;
    logic [7:0]         r_deframe_shift, n_deframe_shift;
    logic [3:0]         r_frame_count, n_frame_count;
    logic [7:0]         r_frame_shift, n_frame_shift;

    spe_pkg::t_result   res;
    spe_pkg::t_q_cmd    q_cmd;
    spe_pkg::t_q_stat   q_stat;
    logic [7:0]         head_byte;

    logic               in_acc;
    logic               s1_fire;
    logic               s1_nl;
    logic               ovf;
    logic [2:0]         df_idx, fr_idx;

    assign s1_fire = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_nl   = r_s1_valid && (spe_pkg::t_func'(r_s1.func) == spe_pkg::FUNC_PUSH)
                     && (r_s1.char_in == spe_pkg::CHAR_LF);
    assign i_in.ready = !s1_nl && (!r_s1_valid || s1_fire);
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign df_idx = 3'(r_deframe_count - 4'd1);
    assign fr_idx = 3'(r_frame_count - 4'd1);
    assign ovf    = (r_s1.char_in == spe_pkg::CHAR_LF) ? !q_stat.room_two : !q_stat.room_one;

    always_comb begin
        n_pins          = r_pins;
        n_deframe_count = r_deframe_count;
        n_deframe_shift = r_deframe_shift;
        n_frame_count   = r_frame_count;
        n_frame_shift   = r_frame_shift;
        res             = '0;
        q_cmd           = '0;
        q_cmd.rd_issue  = in_acc;
        case (spe_pkg::t_func'(r_s1.func))
            spe_pkg::FUNC_TX_BIT: begin
                if (r_deframe_count == 4'd0) begin
                    if (!r_s1.bit_value) n_deframe_count = 4'd1;
                end else if (r_deframe_count < spe_pkg::FRAME_STOP) begin
                    n_deframe_shift[df_idx] = r_s1.bit_value;
                    n_deframe_count = r_deframe_count + 4'd1;
                end else begin
                    res.out_valid   = 1'b1;
                    res.out_byte    = r_deframe_shift;
                    n_deframe_count = 4'd0;
                    n_deframe_shift = 8'd0;
                end
            end
            spe_pkg::FUNC_RX_TICK: begin
                if (!q_stat.empty) begin
                    if (r_frame_count == 4'd0) begin
                        n_pins = spe_pkg::drive_pins(r_pins, spe_pkg::PIN_RXD, 1'b0, r_loop);
                        n_frame_count = 4'd1;
                    end else if (r_frame_count < spe_pkg::FRAME_STOP) begin
                        n_frame_shift[fr_idx] = head_byte[fr_idx];
                        n_pins = spe_pkg::drive_pins(r_pins, spe_pkg::PIN_RXD,
                                                     head_byte[fr_idx], r_loop);
                        n_frame_count = r_frame_count + 4'd1;
                    end else begin
                        res.in_valid  = 1'b1;
                        res.in_byte   = r_frame_shift;
                        n_pins = spe_pkg::drive_pins(r_pins, spe_pkg::PIN_RXD, 1'b1, r_loop);
                        q_cmd.pop     = s1_fire;
                        n_frame_count = 4'd0;
                        n_frame_shift = 8'd0;
                    end
                end
            end
            spe_pkg::FUNC_PUSH: begin
                res.queue_overflow = ovf;
                q_cmd.push    = s1_fire && !ovf;
                q_cmd.push_nl = s1_fire && !ovf && (r_s1.char_in == spe_pkg::CHAR_LF);
            end
            spe_pkg::FUNC_PIN_WRITE: begin
                if (r_s1.pin_number >= spe_pkg::PIN_FIRST && r_s1.pin_number <= spe_pkg::PIN_LAST)
                begin
                    n_pins = spe_pkg::drive_pins(r_pins, 26'(1) << r_s1.pin_number,
                                                 r_s1.bit_value, r_loop);
                end
            end
            default: begin
                n_pins = r_pins;
            end
        endcase
        res.flag_edge   = (|(r_pins & spe_pkg::PIN_RXD)) && !(|(n_pins & spe_pkg::PIN_RXD));
        res.port_pins   = n_pins;
        res.queue_empty = q_stat.empty_next;
    end

    spe_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_char     (r_s1.char_in),
        .o_stat     (q_stat),
        .o_head_byte(head_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop          <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pins          <= '0;
            r_deframe_count <= '0;
            r_deframe_shift <= '0;
            r_frame_count   <= '0;
            r_frame_shift   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_loop <= i_cfg.loopback_enable;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid     <= 1'b1;
                r_pins          <= n_pins;
                r_deframe_count <= n_deframe_count;
                r_deframe_shift <= n_deframe_shift;
                r_frame_count   <= n_frame_count;
                r_frame_shift   <= n_frame_shift;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.func       <= i_in.func;
            r_s1.bit_value  <= i_in.bit_value;
            r_s1.char_in    <= i_in.char_in;
            r_s1.pin_number <= i_in.pin_number;
        end
        if (s1_fire) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_valid      = r_out.out_valid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.in_valid       = r_out.in_valid;
    assign o_out.in_byte        = r_out.in_byte;
    assign o_out.flag_edge      = r_out.flag_edge;
    assign o_out.port_pins      = r_out.port_pins;
    assign o_out.queue_overflow = r_out.queue_overflow;
    assign o_out.queue_empty    = r_out.queue_empty;

    `SPE_ASSERT_NOW(a_frame_needs_char, r_frame_count != 4'd0, !q_stat.empty,
                    "framing with empty queue")
    `SPE_ASSERT_NOW(a_deframe_bound, 1'b1, r_deframe_count <= spe_pkg::FRAME_STOP,
                    "deframe count overrun")
    `SPE_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_fire, r_s1_valid,
                     "stalled request dropped")
endmodule

>>> src/spe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/spe_queue.sv
// Host character queue: ring buffer in RAM with head, level and write forwarding.
`include "serial_port_bit_engine_defines.svh"
module spe_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spe_pkg::t_q_cmd i_cmd,
    input  logic [7:0]      i_char,
    output spe_pkg::t_q_stat o_stat,
    output logic [7:0]      o_head_byte
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [LW-1:0] r_level, n_level;
    logic          r_cr_pend;
    logic [AW-1:0] r_cr_addr;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_data;

    logic [SW-1:0] s_tail, s_cr, s_inc;
    logic [AW-1:0] tail_addr, cr_addr, head_inc;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    ram_q;

    assign s_tail = SW'(r_head) + SW'(r_level);
    assign s_cr   = s_tail + SW'(1);
    assign s_inc  = SW'(r_head) + SW'(1);

    assign tail_addr = (s_tail >= SW'(QUEUE_DEPTH)) ? AW'(s_tail - SW'(QUEUE_DEPTH))
                                                    : AW'(s_tail);
    assign cr_addr   = (s_cr >= SW'(QUEUE_DEPTH)) ? AW'(s_cr - SW'(QUEUE_DEPTH))
                                                  : AW'(s_cr);
    assign head_inc  = (s_inc >= SW'(QUEUE_DEPTH)) ? AW'(s_inc - SW'(QUEUE_DEPTH))
                                                   : AW'(s_inc);

    always_comb begin
        n_head  = i_cmd.pop ? head_inc : r_head;
        n_level = r_level;
        if (i_cmd.pop) begin
            n_level = r_level - LW'(1);
        end else if (i_cmd.push_nl) begin
            n_level = r_level + LW'(2);
        end else if (i_cmd.push) begin
            n_level = r_level + LW'(1);
        end
    end

    assign we    = i_cmd.push || r_cr_pend;
    assign waddr = i_cmd.push ? tail_addr : r_cr_addr;
    assign wdata = i_cmd.push ? i_char : spe_pkg::CHAR_CR;

    spe_ram #(
        .WIDTH(8),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(n_head),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_level   <= '0;
            r_cr_pend <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_level   <= n_level;
            r_cr_pend <= i_cmd.push_nl;
            if (i_cmd.rd_issue) begin
                r_fwd_hit <= we && (waddr == n_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_nl) begin
            r_cr_addr <= cr_addr;
        end
        if (i_cmd.rd_issue) begin
            r_fwd_data <= wdata;
        end
    end

    assign o_head_byte       = r_fwd_hit ? r_fwd_data : ram_q;
    assign o_stat.empty      = (r_level == '0);
    assign o_stat.room_one   = (r_level != LW'(QUEUE_DEPTH));
    assign o_stat.room_two   = (r_level < LW'(QUEUE_DEPTH - 1));
    assign o_stat.empty_next = (n_level == '0);

    `SPE_ASSERT_NOW(a_no_push_on_cr, r_cr_pend, !i_cmd.push, "push collides with CR write")
    `SPE_ASSERT_NOW(a_level_bound, 1'b1, r_level <= LW'(QUEUE_DEPTH), "queue level overrun")
    `SPE_ASSERT_NOW(a_no_pop_empty, i_cmd.pop, r_level != '0, "pop from empty queue")
    `SPE_ASSERT_NEXT(a_cr_follows, i_cmd.push_nl, r_cr_pend && (r_level >= LW'(2)),
                     "newline push without CR follow-up")
endmodule

>>> dv/tb_serial_port_bit_engine.sv
// Self-checking testbench for the serial port bit engine with a per-request predictor.
`timescale 1ns / 1ps
module tb_serial_port_bit_engine;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_REQS  = 375;

    logic i_clk;
    logic i_rst_n;

    spe_in_if  in_if();
    spe_out_if out_if();
    spe_cfg_if cfg_if();

    serial_port_bit_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    logic [25:0] line_pins = '0;
    logic [3:0]  tx_count  = '0;
    logic [7:0]  tx_shift  = '0;
    logic [3:0]  rx_count  = '0;
    logic [7:0]  rx_shift  = '0;
    logic [7:0]  host_chars[$];
    logic        loop_on   = 1'b0;

    spe_pkg::t_result port_results[$];
    int      fail_cnt       = 0;
    int      effective_cnt  = 0;
    int      cycle_cnt      = 0;
    int      send_idle_pct  = 0;
    int      take_stall_pct = 0;
    int      hold_len       = 0;
    logic    rx_hold        = 1'b0;
    event    hold_go;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic void wire_pins(input logic [25:0] mask, input logic level);
        logic [25:0] m;
        m = mask;
        if (loop_on) begin
            if ((mask & spe_pkg::GRP_TX_RX) != '0) m = m | spe_pkg::GRP_TX_RX;
            if ((mask & spe_pkg::GRP_RTS) != '0) m = m | spe_pkg::GRP_RTS;
            if ((mask & spe_pkg::GRP_CD) != '0) m = m | spe_pkg::GRP_CD;
        end
        if (level) line_pins = line_pins | m;
        else line_pins = line_pins & ~m;
    endfunction

    function automatic spe_pkg::t_result predict_port(input spe_pkg::t_item it,
                                                      output bit worked);
        spe_pkg::t_result r;
        logic    old_rxd;
        logic    b;
        int      n;
        int      need;
        r = '0;
        worked = 1'b0;
        old_rxd = (line_pins & spe_pkg::PIN_RXD) != '0;
        case (it.func)
            spe_pkg::FUNC_TX_BIT: begin
                worked = 1'b1;
                if (tx_count == 0) begin
                    if (!it.bit_value) tx_count = 4'd1;
                    else worked = 1'b0;
                end else if (tx_count < spe_pkg::FRAME_STOP) begin
                    tx_shift[tx_count - 1] = it.bit_value;
                    tx_count = tx_count + 4'd1;
                end else begin
                    r.out_valid = 1'b1;
                    r.out_byte = tx_shift;
                    tx_count = '0;
                    tx_shift = '0;
                end
            end
            spe_pkg::FUNC_RX_TICK: begin
                if (host_chars.size() != 0) begin
                    worked = 1'b1;
                    if (rx_count == 0) begin
                        wire_pins(spe_pkg::PIN_RXD, 1'b0);
                        rx_count = 4'd1;
                    end else if (rx_count < spe_pkg::FRAME_STOP) begin
                        n = rx_count - 1;
                        b = host_chars[0][n];
                        rx_shift[n] = b;
                        wire_pins(spe_pkg::PIN_RXD, b);
                        rx_count = rx_count + 4'd1;
                    end else begin
                        r.in_valid = 1'b1;
                        r.in_byte = rx_shift;
                        wire_pins(spe_pkg::PIN_RXD, 1'b1);
                        void'(host_chars.pop_front());
                        rx_count = '0;
                        rx_shift = '0;
                    end
                end
            end
            spe_pkg::FUNC_PUSH: begin
                worked = 1'b1;
                need = (it.char_in == spe_pkg::CHAR_LF) ? 2 : 1;
                if (host_chars.size() + need > QUEUE_DEPTH) begin
                    r.queue_overflow = 1'b1;
                end else begin
                    host_chars.push_back(it.char_in);
                    if (it.char_in == spe_pkg::CHAR_LF) host_chars.push_back(spe_pkg::CHAR_CR);
                end
            end
            default: begin
                if (it.pin_number >= spe_pkg::PIN_FIRST &&
                    it.pin_number <= spe_pkg::PIN_LAST) begin
                    worked = 1'b1;
                    wire_pins(26'(1) << it.pin_number, it.bit_value);
                end
            end
        endcase
        r.flag_edge = old_rxd && ((line_pins & spe_pkg::PIN_RXD) == '0);
        r.port_pins = line_pins;
        r.queue_empty = host_chars.size() == 0;
        return r;
    endfunction

    function automatic spe_pkg::t_item make_req(input spe_pkg::t_func f, input logic b,
                                                input logic [7:0] c, input logic [4:0] p);
        spe_pkg::t_item it;
        it.func = f;
        it.bit_value = b;
        it.char_in = c;
        it.pin_number = p;
        return it;
    endfunction

    task automatic send_req(input spe_pkg::t_item it);
        bit worked;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.func       <= it.func;
        in_if.bit_value  <= it.bit_value;
        in_if.char_in    <= it.char_in;
        in_if.pin_number <= it.pin_number;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        port_results.push_back(predict_port(it, worked));
        if (worked) effective_cnt++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (port_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_loopback(input logic v);
        cfg_if.valid           <= 1'b1;
        cfg_if.loopback_enable <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        loop_on = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [25:0] want,
                               input logic [25:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_result();
        spe_pkg::t_result want;
        if (port_results.size() == 0) begin
            $display("%0t ns: result with none expected, expected none, actual pins %0h",
                     $time, out_if.port_pins);
            fail_cnt++;
        end else begin
            want = port_results.pop_front();
            check_field("out_valid", want.out_valid, out_if.out_valid);
            check_field("out_byte", want.out_byte, out_if.out_byte);
            check_field("in_valid", want.in_valid, out_if.in_valid);
            check_field("in_byte", want.in_byte, out_if.in_byte);
            check_field("flag_edge", want.flag_edge, out_if.flag_edge);
            check_field("port_pins", want.port_pins, out_if.port_pins);
            check_field("queue_overflow", want.queue_overflow, out_if.queue_overflow);
            check_field("queue_empty", want.queue_empty, out_if.queue_empty);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) check_result();
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !rx_hold && ($urandom_range(99) >= take_stall_pct);
        end
    end

    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            rx_hold = 1'b1;
            repeat (hold_len) @(posedge i_clk);
            rx_hold = 1'b0;
        end
    end

    task automatic test_deframer();
        logic [7:0] pattern;
        pattern = 8'hA5;
        send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'b1, 8'hFF, 5'd31));
        send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'b0, 8'h00, 5'd0));
        for (int i = 0; i < 8; i++)
            send_req(make_req(spe_pkg::FUNC_TX_BIT, pattern[i], 8'($urandom), 5'($urandom)));
        send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'b0, 8'($urandom), 5'($urandom)));
    endtask

    task automatic test_empty_tick();
        send_req(make_req(spe_pkg::FUNC_RX_TICK, 1'b1, 8'($urandom), 5'($urandom)));
    endtask

    task automatic test_queue_full();
        repeat (7)
            send_req(make_req(spe_pkg::FUNC_PUSH, 1'($urandom), spe_pkg::CHAR_LF,
                              5'($urandom)));
        send_req(make_req(spe_pkg::FUNC_PUSH, 1'b0, 8'hFF, 5'd0));
        send_req(make_req(spe_pkg::FUNC_PUSH, 1'b1, spe_pkg::CHAR_LF, 5'd31));
        send_req(make_req(spe_pkg::FUNC_PUSH, 1'b0, 8'h00, 5'd0));
        send_req(make_req(spe_pkg::FUNC_PUSH, 1'b1, 8'h41, 5'd31));
    endtask

    task automatic test_pin_writes();
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd0));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd31));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd3));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b0, 8'($urandom), 5'd3));
    endtask

    task automatic test_loopback_groups();
        drain_results();
        set_loopback(1'b1);
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd2));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd20));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd5));
        send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'b1, 8'($urandom), 5'd25));
    endtask

    task automatic test_input_backpressure();
        drain_results();
        send_idle_pct = 0;
        take_stall_pct = 0;
        hold_len = 120;
        -> hold_go;
        repeat (40)
            send_req(make_req(spe_pkg::t_func'($urandom_range(3)), 1'($urandom),
                              8'($urandom), 5'($urandom)));
        drain_results();
    endtask

    task automatic random_traffic(input int target);
        int   goal;
        int   n;
        int   kind;
        logic [4:0] p;
        goal = effective_cnt + target;
        while (effective_cnt < goal) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                n = $urandom_range(2);
                repeat (n)
                    send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'b1, 8'($urandom),
                                      5'($urandom)));
                send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'b0, 8'($urandom), 5'($urandom)));
                repeat (9)
                    send_req(make_req(spe_pkg::FUNC_TX_BIT, 1'($urandom), 8'($urandom),
                                      5'($urandom)));
            end else if (kind < 35) begin
                n = ($urandom_range(4) == 0) ? 18 : $urandom_range(1, 8);
                repeat (n)
                    send_req(make_req(spe_pkg::FUNC_PUSH, 1'($urandom),
                                      ($urandom_range(4) == 0) ? spe_pkg::CHAR_LF
                                                               : 8'($urandom),
                                      5'($urandom)));
            end else if (kind < 60) begin
                n = $urandom_range(1, 60);
                repeat (n)
                    send_req(make_req(spe_pkg::FUNC_RX_TICK, 1'($urandom), 8'($urandom),
                                      5'($urandom)));
            end else if (kind < 80) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        p = $urandom_range(1) ? 5'd0 : 5'($urandom_range(26, 31));
                    else
                        p = 5'($urandom_range(1, 25));
                    send_req(make_req(spe_pkg::FUNC_PIN_WRITE, 1'($urandom), 8'($urandom),
                                      p));
                end
            end else begin
                send_req(make_req(spe_pkg::t_func'($urandom_range(3)), 1'($urandom),
                                  8'($urandom), 5'($urandom)));
            end
        end
    endtask

    task automatic run_phase(input logic loop, input int idle_pct, input int stall_pct);
        drain_results();
        set_loopback(loop);
        send_idle_pct = idle_pct;
        take_stall_pct = stall_pct;
        random_traffic(PHASE_REQS);
        drain_results();
    endtask

    task automatic test_random_phases();
        run_phase(1'b0, 0, 0);
        run_phase(1'b1, 63, 0);
        run_phase(1'b0, 0, 63);
        run_phase(1'b1, 26, 26);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.func             = spe_pkg::FUNC_TX_BIT;
        in_if.bit_value        = 1'b0;
        in_if.char_in          = '0;
        in_if.pin_number       = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.loopback_enable = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_deframer();
        test_empty_tick();
        test_pin_writes();
        test_queue_full();
        test_loopback_groups();
        test_input_backpressure();
        test_random_phases();

        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_cnt == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
